[hw/rtl/sha1bs_pkg.sv]
// sha1bs_pkg: shared constants and control struct of the sha-1 byte stream hasher
`default_nettype none

package sha1bs_pkg;

  // round constants
  localparam logic [31:0] SHA_K0 = 32'h5a827999;
  localparam logic [31:0] SHA_K1 = 32'h6ed9eba1;
  localparam logic [31:0] SHA_K2 = 32'h8f1bbcdc;
  localparam logic [31:0] SHA_K3 = 32'hca62c1d6;

  // initial chaining value, index 0 first
  localparam logic [0:4][31:0] IV_WORDS = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_B1   = 7'd20;
  localparam logic [6:0] ROUND_B2   = 7'd40;
  localparam logic [6:0] ROUND_B3   = 7'd60;

  localparam logic [2:0] WORD_LAST = 3'd4;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // sequencer to datapath
  typedef struct packed {
    logic       put_byte;
    logic [7:0] byte_val;
    logic       load_work;
    logic       round_en;
    logic [6:0] round_idx;
    logic       fold;
    logic       reload_iv;
    logic [2:0] word_idx;
  } sha1bs_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/sha1bs_if.sv]
// sha1bs_if: valid/ready channels for message items and digest items
`default_nettype none

interface sha1bs_msg_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source(output valid, output operation, output data_byte, input ready);
  modport sink(input valid, input operation, input data_byte, output ready);
endinterface

interface sha1bs_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source(output valid, output digest_word, output word_index, output last,
                 input ready);
  modport sink(input valid, input digest_word, input word_index, input last,
               output ready);
endinterface

`default_nettype wire

[hw/rtl/sha1_byte_stream_hasher_top.sv]
// sha1_byte_stream_hasher_top: sha-1 hasher over a stream of message bytes
`default_nettype none

// SHA-1 over a byte stream. Each msg item either appends data_byte to the
// message (operation 0) or finishes it (operation 1); a finish item pads the
// message, compresses the last block(s) and returns five digest items, H0
// first, with last set on the fifth; the hasher then starts over from the
// initial value. An append item leaves the hasher ready for the next one, except the
// one that fills a 64-byte block, which is followed by a busy stretch (80 rounds
// through the single shared round adder, then one fold into the chaining words).
// A finish item puts 9 to 72 padding bytes, one per cycle except while the
// rounds and the fold run for each of the one or two blocks it closes, and then the five
// digest items, one per cycle while digest.ready is high. msg.ready is low
// for the whole time an item is being worked on.
module sha1_byte_stream_hasher_top (
  input wire              clk,
  input wire              rst,
  sha1bs_msg_if.sink      msg,
  sha1bs_digest_if.source digest
);
  import sha1bs_pkg::*;

  sha1bs_ctl_t ctl;
  logic [31:0] w_cur;

  // sequencer: handshakes, byte counting, padding and round count
  sha1bs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_ready   (msg.ready),
    .operation  (msg.operation),
    .data_byte  (msg.data_byte),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .word_index (digest.word_index),
    .last       (digest.last),
    .ctl        (ctl)
  );

  // block buffer, shifted by bytes while loading and by words while hashing
  sha1bs_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  // round unit and chaining words; digest word picked by word index
  sha1bs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .w_cur       (w_cur),
    .digest_word (digest.digest_word)
  );

endmodule

`default_nettype wire

[hw/rtl/sha1bs_sched.sv]
// sha1bs_sched: 64-byte block buffer and message schedule as one shift line
`default_nettype none

module sha1bs_sched (
  input  wire                      clk,
  input  sha1bs_pkg::sha1bs_ctl_t  ctl,
  output logic [31:0]              w_cur
);
  import sha1bs_pkg::*;

  // word slot s sits at bits 511-32s downto 480-32s, slot 0 is the current word
  logic [511:0] blk;
  logic [31:0]  w_mix;

  assign w_cur = blk[511:480];
  assign w_mix = blk[511-32*13 -: 32] ^ blk[511-32*8 -: 32]
               ^ blk[511-32*2 -: 32] ^ blk[511:480];

  always_ff @(posedge clk) begin
    if (ctl.put_byte) begin
      blk <= {blk[503:0], ctl.byte_val};
    end else if (ctl.round_en) begin
      blk <= {blk[479:0], w_mix[30:0], w_mix[31]};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sha1bs_core.sv]
// sha1bs_core: working variables, shared round unit and chaining words
`default_nettype none

module sha1bs_core (
  input  wire                      clk,
  input  wire                      rst,
  input  sha1bs_pkg::sha1bs_ctl_t  ctl,
  input  wire  [31:0]              w_cur,
  output logic [31:0]              digest_word
);
  import sha1bs_pkg::*;

  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t;

  // round function and constant by round group
  always_comb begin
    if (ctl.round_idx < ROUND_B1) begin
      f = d ^ (b & (c ^ d));
      k = SHA_K0;
    end else if (ctl.round_idx < ROUND_B2) begin
      f = b ^ c ^ d;
      k = SHA_K1;
    end else if (ctl.round_idx < ROUND_B3) begin
      f = (b & c) | (d & (b | c));
      k = SHA_K2;
    end else begin
      f = b ^ c ^ d;
      k = SHA_K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_cur;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (ctl.round_en) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reload_iv) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= IV_WORDS[i];
      end
    end else if (ctl.fold) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

  always_comb begin
    case (ctl.word_idx)
      3'd0:    digest_word = h[0];
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      default: digest_word = h[4];
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sha1bs_ctrl.sv]
// sha1bs_ctrl: sequencer for byte loading, padding, rounds and digest output
`default_nettype none

module sha1bs_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      operation,
  input  wire  [7:0]               data_byte,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [2:0]               word_index,
  output logic                     last,
  output sha1bs_pkg::sha1bs_ctl_t  ctl
);
  import sha1bs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [31:0] msg_bytes;
  logic [63:0] len_sr;
  logic        finishing, mark_done, len_phase, pad_done;
  logic [6:0]  round_cnt;
  logic [2:0]  word_cnt;

  logic       accept, append, finish, len_byte, block_full, out_take;
  logic [7:0] pad_byte;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_EMIT);
  assign word_index = word_cnt;
  assign last       = (word_cnt == WORD_LAST);

  assign accept   = in_valid && in_ready;
  assign append   = accept && (operation == OP_APPEND);
  assign finish   = accept && (operation == OP_FINISH);
  assign out_take = out_valid && out_ready;
  // length bytes fill the last eight places of the final block
  assign len_byte = mark_done && (len_phase || fill == LEN_POS);
  assign pad_byte = !mark_done ? PAD_MARK : (len_byte ? len_sr[63:56] : 8'h00);

  always_comb begin
    ctl.put_byte  = append || (state == S_PAD);
    ctl.byte_val  = (state == S_PAD) ? pad_byte : data_byte;
    ctl.load_work = 1'b0;
    ctl.round_en  = (state == S_ROUND);
    ctl.round_idx = round_cnt;
    ctl.fold      = (state == S_FOLD);
    ctl.reload_iv = out_take && last;
    ctl.word_idx  = word_cnt;
    block_full    = ctl.put_byte && (fill == FILL_LAST);
    ctl.load_work = block_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      msg_bytes <= '0;
      finishing <= 1'b0;
      mark_done <= 1'b0;
      len_phase <= 1'b0;
      pad_done  <= 1'b0;
      round_cnt <= '0;
      word_cnt  <= '0;
    end else begin
      if (ctl.put_byte) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (append) begin
            msg_bytes <= msg_bytes + 32'd1;
            if (block_full) begin
              state     <= S_ROUND;
              round_cnt <= '0;
            end
          end else if (finish) begin
            msg_bytes <= '0;
            finishing <= 1'b1;
            mark_done <= 1'b0;
            len_phase <= 1'b0;
            pad_done  <= 1'b0;
            state     <= S_PAD;
          end
        end
        S_PAD: begin
          mark_done <= 1'b1;
          if (len_byte) begin
            len_phase <= 1'b1;
            if (fill == FILL_LAST) begin
              pad_done <= 1'b1;
            end
          end
          if (block_full) begin
            state     <= S_ROUND;
            round_cnt <= '0;
          end
        end
        S_ROUND: begin
          round_cnt <= round_cnt + 7'd1;
          if (round_cnt == ROUND_LAST) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (pad_done) begin
            state <= S_EMIT;
          end else if (finishing) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_take) begin
            if (last) begin
              word_cnt  <= '0;
              finishing <= 1'b0;
              pad_done  <= 1'b0;
              state     <= S_IDLE;
            end else begin
              word_cnt <= word_cnt + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // bit length of the message, shifted out a byte at a time
  always_ff @(posedge clk) begin
    if (finish) begin
      len_sr <= {29'd0, msg_bytes, 3'd0};
    end else if ((state == S_PAD) && len_byte) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sha1bs_checker.sv]
// sha1bs_checker: port-level assertions for the sha-1 hasher, bound to the top
`default_nettype none

module sha1bs_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] word_index,
  input wire       last
);
  import sha1bs_pkg::*;

  // no new item is taken while digest items are pending
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready while digest items pending");

  // last marks the fifth word only
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (word_index == WORD_LAST)))
    else $error("last does not match word index");

  // digest words follow each other in order
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  // after the final word the hasher is ready again
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("not ready after digest");

  // stalled digest item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("digest item dropped while stalled");

endmodule

bind sha1_byte_stream_hasher_top sha1bs_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (msg.ready),
  .out_valid  (digest.valid),
  .out_ready  (digest.ready),
  .word_index (digest.word_index),
  .last       (digest.last)
);

`default_nettype wire

[test/testbench.sv]
// testbench: self-checking random and directed test of the sha-1 byte stream hasher
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1bs_pkg::OP_APPEND;
  import sha1bs_pkg::OP_FINISH;

  // cycles without any accepted item before the run is abandoned;
  // worst case is a two-block finish (72 pad bytes and the rounds and fold of
  // both blocks) plus sender and receiver stalls, taken several times over
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_ITEMS = 420;
  localparam int CALM_ITEMS = 60;
  localparam int SHOWN_ERRORS = 20;

  // own copy of the round constants and initial chaining value
  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic clk;
  logic rst;

  sha1bs_msg_if    msg_ch ();
  sha1bs_digest_if dig_ch ();

  sha1_byte_stream_hasher_top dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  // predictor state: chaining words, block buffer, fill level, byte count
  logic [31:0] chain_h [5];
  logic [31:0] block_w [16];
  logic [5:0]  block_fill_cnt;
  logic [31:0] msg_len_bytes;

  msg_item_t    pending_items [$];
  digest_item_t digest_due [$];

  int errors;
  int sent;
  int calm_from;
  int src_gap;
  int snk_gap;
  int idle_cycles;
  int digests_checked;
  int messages_hashed;
  int bytes_hashed;
  int longest_msg;
  int cur_len;
  bit calm;

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // reference sha-1 predictor
  // ---------------------------------------------------------------------------

  // 80 rounds over the 16-word block, folded into the chaining words
  function automatic void sha1_compress();
    logic [31:0] a, b, c, d, e, f, w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      // message schedule kept in place in the 16-word window
      if (r >= 16) begin
        w = block_w[(r + 13) & 15] ^ block_w[(r + 8) & 15] ^
            block_w[(r + 2) & 15] ^ block_w[r & 15];
        block_w[r & 15] = {w[30:0], w[31]};
      end
      if (r < 20) f = (d ^ (b & (c ^ d))) + K_R0;
      else if (r < 40) f = (b ^ c ^ d) + K_R1;
      else if (r < 60) f = ((b & c) | (d & (b | c))) + K_R2;
      else f = (b ^ c ^ d) + K_R3;
      f = f + {a[26:0], a[31:27]} + e + block_w[r & 15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = f;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // big-endian byte lanes; a full block triggers compression
  function automatic void sha1_absorb(logic [7:0] v);
    int lane;
    lane = 24 - 8 * block_fill_cnt[1:0];
    block_w[block_fill_cnt[5:2]][lane +: 8] = v;
    block_fill_cnt = block_fill_cnt + 6'd1;
    if (block_fill_cnt == 6'd0) sha1_compress();
  endfunction

  function automatic void sha1_reset();
    for (int k = 0; k < 5; k++) chain_h[k] = H_INIT[k];
    block_fill_cnt = '0;
    msg_len_bytes = '0;
  endfunction

  // one accepted item: append a byte, or pad and queue the five digest words
  function automatic void sha1_predict(msg_item_t it);
    logic [63:0] bit_len;
    if (it.op == OP_APPEND) begin
      msg_len_bytes = msg_len_bytes + 32'd1;
      sha1_absorb(it.data);
    end else begin
      // length field holds the 32-bit byte count times 8, so at most 35 bits
      bit_len = {29'd0, msg_len_bytes, 3'd0};
      sha1_absorb(8'h80);
      while (block_fill_cnt != 6'd56) sha1_absorb(8'h00);
      for (int k = 7; k >= 0; k--) sha1_absorb(bit_len[8 * k +: 8]);
      for (int k = 0; k < 5; k++)
        digest_due.push_back('{word: chain_h[k], index: 3'(k), last: (k == 4)});
      sha1_reset();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_item(logic op, logic [7:0] data);
    pending_items.push_back('{op: op, data: data});
  endtask

  // a whole message of random bytes, closed by a finish with random filler data
  task automatic add_message(int len);
    for (int i = 0; i < len; i++) add_item(OP_APPEND, 8'($urandom_range(0, 255)));
    add_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= SHOWN_ERRORS)
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued items on the message channel, with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    msg_item_t cur;
    if (rst) begin
      msg_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      // item taken by the hasher this edge: feed the predictor
      if (msg_ch.valid && msg_ch.ready) begin
        sha1_predict('{op: msg_ch.operation, data: msg_ch.data_byte});
        sent++;
        calm = (sent >= calm_from);
        if (msg_ch.operation == OP_FINISH) begin
          messages_hashed++;
          if (cur_len > longest_msg) longest_msg = cur_len;
          cur_len = 0;
        end else begin
          bytes_hashed++;
          cur_len++;
        end
      end
      // channel free: idle a while or load the next item
      if (!msg_ch.valid || msg_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          msg_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          msg_ch.operation <= cur.op;
          msg_ch.data_byte <= cur.data;
          msg_ch.valid <= 1'b1;
          // burst of idle cycles after this item, now and then
          if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          msg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure and in-order digest checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_item_t want;
    if (rst) begin
      dig_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (dig_ch.valid && dig_ch.ready) begin
        if (digest_due.size() == 0) begin
          report_mismatch("unexpected digest item", dig_ch.digest_word, '0);
        end else begin
          want = digest_due.pop_front();
          digests_checked++;
          if (dig_ch.digest_word !== want.word)
            report_mismatch("digest_word", dig_ch.digest_word, want.word);
          if (dig_ch.word_index !== want.index)
            report_mismatch("word_index", 32'(dig_ch.word_index), 32'(want.index));
          if (dig_ch.last !== want.last)
            report_mismatch("last", 32'(dig_ch.last), 32'(want.last));
        end
      end
      // stall bursts on the receiving side
      if (snk_gap > 0) begin
        snk_gap--;
        dig_ch.ready <= 1'b0;
      end else begin
        dig_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a run with no accepted item for too long is a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int total;
    int len;
    clk = 1'b0;
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.operation = OP_APPEND;
    msg_ch.data_byte = 8'h00;
    dig_ch.ready = 1'b0;
    errors = 0;
    sent = 0;
    calm = 1'b0;
    calm_from = 32'h7fffffff;
    idle_cycles = 0;
    digests_checked = 0;
    messages_hashed = 0;
    bytes_hashed = 0;
    longest_msg = 0;
    cur_len = 0;
    sha1_reset();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message with all-ones filler on the finish
    add_item(OP_FINISH, 8'hff);
    // "abc"
    add_item(OP_APPEND, 8'h61);
    add_item(OP_APPEND, 8'h62);
    add_item(OP_APPEND, 8'h63);
    add_item(OP_FINISH, 8'h00);
    // byte extremes and the pad marker value itself as data
    add_item(OP_APPEND, 8'h00);
    add_item(OP_APPEND, 8'hff);
    add_item(OP_APPEND, 8'h80);
    add_item(OP_APPEND, 8'h7f);
    add_item(OP_FINISH, 8'h55);
    // back-to-back empty messages
    add_item(OP_FINISH, 8'haa);
    add_item(OP_FINISH, 8'h00);

    // hold the sender until every digest word of the directed part is back
    while (pending_items.size() != 0 || msg_ch.valid || digest_due.size() != 0)
      @(posedge clk);

    // random messages; lengths mostly short, some on the padding boundaries
    // (55/56 bytes decide one or two closing blocks, 63/64 a full block)
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 12);
        4, 5, 6:    len = $urandom_range(13, 70);
        7, 8:       len = 55 + $urandom_range(0, 10);
        default:    len = 64 * $urandom_range(1, 2) - 9 + $urandom_range(0, 2);
      endcase
      add_message(len);
      total += len + 1;
    end
    // no idling in the closing stretch
    calm_from = sent + pending_items.size() - CALM_ITEMS;

    // all items taken and all digests back, then a short quiet tail
    while (pending_items.size() != 0 || msg_ch.valid || digest_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("hashed %0d messages, %0d bytes in all, longest %0d bytes",
             messages_hashed, bytes_hashed, longest_msg);
    $display("checked %0d digest words, %0d mismatches", digests_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/sha1bs_pkg.sv
hw/rtl/sha1bs_if.sv
hw/rtl/sha1bs_sched.sv
hw/rtl/sha1bs_core.sv
hw/rtl/sha1bs_ctrl.sv
hw/rtl/sha1_byte_stream_hasher_top.sv
hw/rtl/sha1bs_checker.sv
test/testbench.sv
